[hdl/mrope_pkg.sv]
package mrope_pkg;

	localparam int GRID_W   = 9;
	localparam int POS_W    = 16;
	localparam int MAX_GRID = 256;

	typedef struct packed {
		logic              action;
		logic              first;
		logic [GRID_W-1:0] grid_h;
		logic [GRID_W-1:0] grid_w;
		logic              grid_bad;
		logic [POS_W-1:0]  span_red;
	} mrope_cmd_t;

	typedef struct packed {
		logic [POS_W-1:0] pos_t;
		logic [POS_W-1:0] pos_h;
		logic [POS_W-1:0] pos_w;
		logic             last_of_span;
		logic             error;
	} mrope_res_t;

endpackage

[hdl/mrope_fifo.sv]
module mrope_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/mrope_front.sv]
module mrope_front
	import mrope_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              action,
	input  logic              first_of_sequence,
	input  logic [GRID_W-1:0] grid_h,
	input  logic [GRID_W-1:0] grid_w,
	output logic              cmd_valid,
	output mrope_cmd_t        cmd,
	input  logic              cmd_ready
);

	localparam int PROD_W = 2 * GRID_W;

	logic              v_s1;
	mrope_cmd_t        cmd_s1;
	mrope_cmd_t        cmd_in;
	logic [PROD_W-1:0] prod;
	logic [GRID_W-1:0] longest;
	logic              accept;

	assign full      = v_s1 && !cmd_ready;
	assign accept    = push && !full;
	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

	always_comb begin
		prod    = PROD_W'(grid_h) * PROD_W'(grid_w);
		longest = (grid_h > grid_w) ? grid_h : grid_w;
		cmd_in.action   = action;
		cmd_in.first    = first_of_sequence;
		cmd_in.grid_h   = grid_h;
		cmd_in.grid_w   = grid_w;
		cmd_in.grid_bad = (grid_h == '0) || (grid_w == '0) ||
			(32'(grid_h) > 32'(MAX_GRID)) || (32'(grid_w) > 32'(MAX_GRID));
		cmd_in.span_red = POS_W'(prod - PROD_W'(longest));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (cmd_ready) begin
			v_s1 <= 1'b0;
		end
	end

endmodule

[hdl/mrope_back.sv]
module mrope_back
	import mrope_pkg::*;
#(
	parameter int MAX_SEQ = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_empty,
	input  mrope_cmd_t cmd,
	output logic       cmd_pop,
	input  logic       res_full,
	output logic       res_push,
	output mrope_res_t res
);

	localparam int IDX_W = $clog2(MAX_SEQ + 1);
	localparam logic [IDX_W-1:0] SEQ_LIM = IDX_W'(MAX_SEQ);

	logic [IDX_W-1:0]  idx_q;
	logic [POS_W-1:0]  off_q;
	logic              act_q;
	logic [GRID_W-1:0] row_q;
	logic [GRID_W-1:0] col_q;
	logic [POS_W-1:0]  base_q;
	logic [GRID_W-1:0] height_q;
	logic [GRID_W-1:0] width_q;
	logic [POS_W-1:0]  red_q;
	logic              err_q;

	logic              take;
	logic [IDX_W-1:0]  cur_idx;
	logic [POS_W-1:0]  cur_off;
	logic              cur_act;
	logic              cur_err;
	logic              ovf;
	logic [POS_W-1:0]  text_pos;
	logic              use_span;
	logic [POS_W-1:0]  s_base;
	logic [GRID_W-1:0] s_row;
	logic [GRID_W-1:0] s_col;
	logic [GRID_W-1:0] s_h;
	logic [GRID_W-1:0] s_w;
	logic [POS_W-1:0]  s_red;
	logic              col_end;
	logic              row_end;
	logic              last;
	logic              err_n;

	assign take     = !cmd_empty && !res_full;
	assign cmd_pop  = take;
	assign res_push = take;

	always_comb begin
		cur_idx  = cmd.first ? '0 : idx_q;
		cur_off  = cmd.first ? '0 : off_q;
		cur_act  = cmd.first ? 1'b0 : act_q;
		cur_err  = cmd.first ? 1'b0 : err_q;
		ovf      = (cur_idx >= SEQ_LIM);
		text_pos = POS_W'(cur_idx) - cur_off;
		use_span = cmd.action && (cur_act || !cmd.grid_bad);
		s_base   = cur_act ? base_q   : text_pos;
		s_row    = cur_act ? row_q    : '0;
		s_col    = cur_act ? col_q    : '0;
		s_h      = cur_act ? height_q : cmd.grid_h;
		s_w      = cur_act ? width_q  : cmd.grid_w;
		s_red    = cur_act ? red_q    : cmd.span_red;
		col_end  = ({1'b0, s_col} + 1'b1) == {1'b0, s_w};
		row_end  = ({1'b0, s_row} + 1'b1) == {1'b0, s_h};
		last     = use_span && col_end && row_end;
		err_n    = cur_err || ovf ||
			(!cmd.action && cur_act) ||
			(cmd.action && !cur_act && cmd.grid_bad) ||
			(cmd.action && cur_act && ((cmd.grid_h != height_q) || (cmd.grid_w != width_q)));

		res.pos_t        = use_span ? s_base : text_pos;
		res.pos_h        = use_span ? s_base + POS_W'(s_row) : text_pos;
		res.pos_w        = use_span ? s_base + POS_W'(s_col) : text_pos;
		res.last_of_span = last;
		res.error        = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			off_q    <= '0;
			act_q    <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
			base_q   <= '0;
			height_q <= '0;
			width_q  <= '0;
			red_q    <= '0;
			err_q    <= 1'b0;
		end else if (take) begin
			idx_q <= ovf ? cur_idx : cur_idx + 1'b1;
			err_q <= err_n;
			if (use_span) begin
				base_q   <= s_base;
				height_q <= s_h;
				width_q  <= s_w;
				red_q    <= s_red;
				act_q    <= !last;
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q <= '0;
						off_q <= cur_off + s_red;
					end else begin
						row_q <= s_row + 1'b1;
						off_q <= cur_off;
					end
				end else begin
					col_q <= s_col + 1'b1;
					row_q <= s_row;
					off_q <= cur_off;
				end
			end else begin
				act_q <= 1'b0;
				off_q <= cur_off;
			end
		end
	end

`ifndef SYNTH
	a_span_inside: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> (col_q < width_q) && (row_q < height_q))
		else $error("span raster position outside its grid");

	a_span_dims: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> (width_q != '0) && (height_q != '0))
		else $error("active span with a zero dimension");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && !(take && cmd.first) |=> err_q)
		else $error("error flag dropped without sequence start");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.last_of_span |=> !act_q)
		else $error("span still active after its last token");
`endif

endmodule

[hdl/multimodal_rope_position_gen_top.sv]
// Three-axis rotary position generator. Each push is one token, text or image; each pop
// returns its temporal, row and column positions, the end-of-span mark and the sticky
// error flag. One token per clock is sustained in both directions while pops keep up:
// the front stage registers the token and forms the span reduction with one 9x9
// multiply, a two-entry queue feeds the back stage, which updates all sequence state
// for each token it takes, and a two-entry result queue decouples pop. A result passes
// the front stage register, the command queue and the result queue before empty drops.
module multimodal_rope_position_gen_top
	import mrope_pkg::*;
#(
	parameter int MAX_SEQ = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              action,
	input  logic              first_of_sequence,
	input  logic [GRID_W-1:0] grid_h,
	input  logic [GRID_W-1:0] grid_w,
	output logic              empty,
	input  logic              pop,
	output logic [POS_W-1:0]  pos_t,
	output logic [POS_W-1:0]  pos_h,
	output logic [POS_W-1:0]  pos_w,
	output logic              last_of_span,
	output logic              error
);

	localparam int CMD_W = $bits(mrope_cmd_t);
	localparam int RES_W = $bits(mrope_res_t);

	logic       front_valid;
	mrope_cmd_t front_cmd;
	logic       mid_full;
	logic       mid_empty;
	mrope_cmd_t mid_cmd;
	logic       mid_pop;
	logic       out_full;
	logic       out_push;
	mrope_res_t back_res;
	mrope_res_t out_res;

	mrope_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.action            (action),
		.first_of_sequence (first_of_sequence),
		.grid_h            (grid_h),
		.grid_w            (grid_w),
		.cmd_valid         (front_valid),
		.cmd               (front_cmd),
		.cmd_ready         (!mid_full)
	);

	mrope_fifo #(
		.W     (CMD_W),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_valid),
		.wdata  (front_cmd),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_cmd),
		.empty  (mid_empty)
	);

	mrope_back #(
		.MAX_SEQ (MAX_SEQ)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (mid_empty),
		.cmd       (mid_cmd),
		.cmd_pop   (mid_pop),
		.res_full  (out_full),
		.res_push  (out_push),
		.res       (back_res)
	);

	mrope_fifo #(
		.W     (RES_W),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (back_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign pos_t        = out_res.pos_t;
	assign pos_h        = out_res.pos_h;
	assign pos_w        = out_res.pos_w;
	assign last_of_span = out_res.last_of_span;
	assign error        = out_res.error;

endmodule

[tb/tb_multimodal_rope_position_gen_top.sv]
`timescale 1ns / 100ps

module tb_multimodal_rope_position_gen_top;
	import mrope_pkg::*;

	localparam int          MAX_SEQ        = 65536;
	localparam int          RANDOM_ITEMS   = 950;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          MAX_REPORTS    = 100;
	localparam logic        TOKEN_TEXT     = 1'b0;
	localparam logic        TOKEN_IMAGE    = 1'b1;

	typedef enum int {MODE_POP_SLOW, MODE_PUSH_SLOW, MODE_FULL_RATE} idle_mode_t;

	typedef struct {
		logic              act;
		logic              first;
		logic [GRID_W-1:0] gh;
		logic [GRID_W-1:0] gw;
		idle_mode_t        mode;
		bit                wait_drain;
	} token_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              action = 1'b0;
	logic              first_of_sequence = 1'b0;
	logic [GRID_W-1:0] grid_h = '0;
	logic [GRID_W-1:0] grid_w = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [POS_W-1:0]  pos_t;
	logic [POS_W-1:0]  pos_h;
	logic [POS_W-1:0]  pos_w;
	logic              last_of_span;
	logic              error;

	token_item_t pending_tokens[$];
	mrope_res_t  expected_positions[$];
	token_item_t cur_token;
	idle_mode_t  gen_mode = MODE_POP_SLOW;
	idle_mode_t  rx_mode = MODE_POP_SLOW;
	bit          fresh_seq = 1'b0;
	bit          drain_next = 1'b0;
	int          gen_count = 0;
	int          tokens_sent = 0;
	int          results_seen = 0;
	int          spans_closed = 0;
	int          error_results = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;

	int unsigned       tok_idx = 0;
	logic [16:0]       red_amt = '0;
	bit                span_on = 1'b0;
	int unsigned       cur_row = 0;
	int unsigned       cur_col = 0;
	logic [POS_W-1:0]  span_org = '0;
	int unsigned       span_rows = 0;
	int unsigned       span_cols = 0;
	bit                seq_err = 1'b0;

	multimodal_rope_position_gen_top #(
		.MAX_SEQ(MAX_SEQ)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.action           (action),
		.first_of_sequence(first_of_sequence),
		.grid_h           (grid_h),
		.grid_w           (grid_w),
		.empty            (empty),
		.pop              (pop),
		.pos_t            (pos_t),
		.pos_h            (pos_h),
		.pos_w            (pos_w),
		.last_of_span     (last_of_span),
		.error            (error)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned push_gap_pct(idle_mode_t m);
		case (m)
			MODE_POP_SLOW: return 8;
			MODE_PUSH_SLOW: return 53;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned pop_gap_pct(idle_mode_t m);
		case (m)
			MODE_POP_SLOW: return 53;
			MODE_PUSH_SLOW: return 8;
			default: return 0;
		endcase
	endfunction

	function automatic mrope_res_t predict_positions(token_item_t t);
		mrope_res_t  r;
		bit          ovf;
		logic [31:0] txt;
		int unsigned prod;
		int unsigned longest;
		if (t.first) begin
			tok_idx = 0;
			red_amt = '0;
			span_on = 1'b0;
			cur_row = 0;
			cur_col = 0;
			span_org = '0;
			span_rows = 0;
			span_cols = 0;
			seq_err = 1'b0;
		end
		ovf = tok_idx >= MAX_SEQ;
		if (ovf)
			seq_err = 1'b1;
		txt = tok_idx - red_amt;
		r.last_of_span = 1'b0;
		if (t.act == TOKEN_IMAGE) begin
			if (!span_on) begin
				if (t.gh == 0 || t.gw == 0 || t.gh > MAX_GRID || t.gw > MAX_GRID) begin
					seq_err = 1'b1;
				end else begin
					span_on = 1'b1;
					span_rows = t.gh;
					span_cols = t.gw;
					span_org = txt[POS_W-1:0];
					cur_row = 0;
					cur_col = 0;
				end
			end else if (t.gh != span_rows || t.gw != span_cols) begin
				seq_err = 1'b1;
			end
		end else if (span_on) begin
			seq_err = 1'b1;
			span_on = 1'b0;
		end
		if (t.act == TOKEN_IMAGE && span_on) begin
			r.pos_t = span_org;
			r.pos_h = span_org + cur_row[POS_W-1:0];
			r.pos_w = span_org + cur_col[POS_W-1:0];
			if (cur_col + 1 >= span_cols) begin
				cur_col = 0;
				if (cur_row + 1 >= span_rows) begin
					prod = span_rows * span_cols;
					longest = span_rows > span_cols ? span_rows : span_cols;
					r.last_of_span = 1'b1;
					span_on = 1'b0;
					cur_row = 0;
					red_amt = red_amt + 17'(prod - longest);
				end else begin
					cur_row++;
				end
			end else begin
				cur_col++;
			end
		end else begin
			r.pos_t = txt[POS_W-1:0];
			r.pos_h = txt[POS_W-1:0];
			r.pos_w = txt[POS_W-1:0];
		end
		if (!ovf)
			tok_idx++;
		r.error = seq_err;
		return r;
	endfunction

	task automatic add_token(logic act, int unsigned gh, int unsigned gw);
		token_item_t t;
		t.act = act;
		t.first = fresh_seq;
		t.gh = gh[GRID_W-1:0];
		t.gw = gw[GRID_W-1:0];
		t.mode = gen_mode;
		t.wait_drain = drain_next;
		pending_tokens.push_back(t);
		fresh_seq = 1'b0;
		drain_next = 1'b0;
		gen_count++;
	endtask

	// emit a raster span, optionally cut short or with one token carrying a changed grid
	task automatic add_span(int h, int w, int stop_at, int bent_at);
		int n;
		for (n = 0; n < h * w && n != stop_at; n++) begin
			if (n == bent_at)
				add_token(TOKEN_IMAGE, h ^ 1, w);
			else
				add_token(TOKEN_IMAGE, h, w);
		end
	endtask

	always @(posedge clk) begin : token_driver
		token_item_t nxt;
		bit          launch;
		if (arst_n) begin
			if (push && !full) begin
				expected_positions.push_back(predict_positions(cur_token));
				tokens_sent++;
			end
			if (!push || !full) begin
				launch = 1'b0;
				if (pending_tokens.size() != 0) begin
					nxt = pending_tokens[0];
					if (!(nxt.wait_drain && expected_positions.size() != 0) &&
					    $urandom_range(99) >= push_gap_pct(nxt.mode))
						launch = 1'b1;
				end
				if (launch) begin
					void'(pending_tokens.pop_front());
					cur_token = nxt;
					action <= nxt.act;
					first_of_sequence <= nxt.first;
					grid_h <= nxt.gh;
					grid_w <= nxt.gw;
					rx_mode <= nxt.mode;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_monitor
		mrope_res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				results_seen++;
				if (expected_positions.size() == 0) begin
					mismatches++;
					$display("%0t: result with no transaction waiting, pos_t %0d", $time, pos_t);
				end else begin
					want = expected_positions.pop_front();
					if (want.last_of_span)
						spans_closed++;
					if (want.error)
						error_results++;
					check_field("pos_t", want.pos_t, pos_t);
					check_field("pos_h", want.pos_h, pos_h);
					check_field("pos_w", want.pos_w, pos_w);
					check_field("last_of_span", want.last_of_span, last_of_span);
					check_field("error", want.error, error);
				end
			end
			pop <= ($urandom_range(99) >= pop_gap_pct(rx_mode));
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			idle_cycles <= ((push && !full) || (pop && !empty)) ? 0 : idle_cycles + 1;
	end

	initial begin : stimulus
		int base_count;
		int segs;
		int pick;
		int h;
		int w;
		idle_mode_t want_mode;
		bit timed_out;

		fresh_seq = 1'b1;
		add_token(TOKEN_TEXT, 0, 0);
		add_token(TOKEN_IMAGE, 1, 1);
		add_span(2, 3, -1, -1);
		add_token(TOKEN_TEXT, 511, 511);
		add_token(TOKEN_IMAGE, 0, 5);
		add_token(TOKEN_IMAGE, 5, 0);
		add_token(TOKEN_IMAGE, 257, 1);
		add_token(TOKEN_IMAGE, 1, 511);
		fresh_seq = 1'b1;
		add_token(TOKEN_IMAGE, 2, 2);
		fresh_seq = 1'b1;
		add_token(TOKEN_IMAGE, 1, 2);
		add_token(TOKEN_IMAGE, 1, 3);
		add_token(TOKEN_IMAGE, 2, 2);
		add_token(TOKEN_TEXT, 2, 2);
		fresh_seq = 1'b1;
		add_token(TOKEN_TEXT, 0, 0);

		base_count = gen_count;
		while (gen_count - base_count < RANDOM_ITEMS) begin
			want_mode = idle_mode_t'((gen_count - base_count) * 3 / RANDOM_ITEMS);
			if (want_mode != gen_mode) begin
				gen_mode = want_mode;
				drain_next = 1'b1;
			end
			fresh_seq = 1'b1;
			segs = $urandom_range(1, 8);
			repeat (segs) begin
				pick = $urandom_range(99);
				h = $urandom_range(1, 4);
				w = $urandom_range(1, 4);
				if ($urandom_range(19) == 0) begin
					if ($urandom_range(1)) begin
						h = MAX_GRID;
						w = 1;
					end else begin
						h = 1;
						w = MAX_GRID;
					end
				end
				if (pick < 35) begin
					repeat ($urandom_range(1, 4))
						add_token(TOKEN_TEXT, $urandom_range(511), $urandom_range(511));
				end else if (pick < 88) begin
					add_span(h, w, -1, -1);
				end else if (pick < 92) begin
					add_span(h, w, $urandom_range(0, h * w - 1), -1);
				end else if (pick < 95) begin
					add_span(h, w, -1, $urandom_range(0, h * w - 1));
				end else if (pick < 98) begin
					repeat (2)
						add_token(1'($urandom_range(1)), $urandom_range(511),
						          $urandom_range(511));
				end else begin
					fresh_seq = 1'b1;
				end
			end
		end

		// square span at the end of a clean sequence, then text after it
		fresh_seq = 1'b1;
		add_span(16, 16, -1, -1);
		add_token(TOKEN_TEXT, 0, 0);
		fresh_seq = 1'b1;
		add_token(TOKEN_TEXT, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending_tokens.size() != 0 || push || expected_positions.size() != 0) &&
		       idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		timed_out = idle_cycles >= WATCHDOG_LIMIT;
		if (timed_out)
			$display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
			         WATCHDOG_LIMIT, expected_positions.size());
		else
			repeat (10) @(posedge clk);

		$display("%0d tokens sent, %0d results checked, %0d spans closed, %0d flagged in error",
		         tokens_sent, results_seen, spans_closed, error_results);
		$display("ran slow-pop, slow-push and full-rate phases; %0d mismatches", mismatches);
		if (!timed_out && mismatches == 0)
			$display("multimodal_rope_position_gen_top: match");
		else
			$display("multimodal_rope_position_gen_top: mismatch");
		$finish;
	end

endmodule
